[rtl/core/largest_remainder_apportion_assert.svh]
// Assertion macros shared by the apportionment RTL.
`ifndef LARGEST_REMAINDER_APPORTION_ASSERT_SVH
`define LARGEST_REMAINDER_APPORTION_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is low.
`define LRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, including during reset.
`define LRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/lra_pkg.sv]
// Shared types and constants for the largest-remainder apportionment block.
`default_nettype none
package lra_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int LENGTH_BITS = 12;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = LENGTH_BITS + IDX_W + 1;
    localparam int PROD_W = 2 * LENGTH_BITS;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FIX_OVER = 2'd1;
    localparam logic [1:0] STAT_NO_SHARE = 2'd2;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] entry_value;
        logic                   entry_is_share;
        logic                   entry_last;
    } t_entry;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] resolved_length;
        logic [1:0]             status;
        logic                   result_last;
    } t_result;

    // Entry store word.
    typedef struct packed {
        logic                   share;
        logic [LENGTH_BITS-1:0] value;
    } t_ent_word;

    // Quota store word: share flag, floor quota and remainder.
    typedef struct packed {
        logic                   share;
        logic [LENGTH_BITS-1:0] res;
        logic [SUM_W-1:0]       rem;
    } t_quota_word;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [SUM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
        logic [SUM_W-1:0]  rem;
    } t_div_rsp;
endpackage
`default_nettype wire

[rtl/core/lra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                  i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/core/lra_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lra_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lra_pkg::t_div_req i_req,
    output lra_pkg::t_div_rsp      o_rsp
);
    localparam int STEP_W = $clog2(lra_pkg::PROD_W + 1);

    logic [lra_pkg::PROD_W-1:0] r_q;
    logic [lra_pkg::SUM_W-1:0]  r_r;
    logic [lra_pkg::SUM_W-1:0]  r_d;
    logic [STEP_W-1:0]          r_step;
    logic                       r_run;
    logic                       r_done;
    logic [lra_pkg::SUM_W:0]    trial;
    logic                       ge;

    assign trial = {r_r, r_q[lra_pkg::PROD_W-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
                r_step <= STEP_W'(lra_pkg::PROD_W);
                r_run  <= 1'b1;
            end else if (r_run) begin
                // Remainder stays below the divisor, so it fits SUM_W bits.
                r_r    <= ge ? lra_pkg::SUM_W'(trial - {1'b0, r_d})
                             : trial[lra_pkg::SUM_W-1:0];
                r_q    <= {r_q[lra_pkg::PROD_W-2:0], ge};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;
endmodule
`default_nettype wire

[rtl/core/largest_remainder_apportion.sv]
// Largest-remainder apportionment of a configured total length: top level.
//
// Entries load at one per cycle while busy is low; the entry marked last
// raises busy for the final pass. A check state comes first. Each stored
// entry then takes a read, a multiply and a write; a share entry also
// waits on a divide in the shared restoring divider (load, PROD_W (24)
// quotient bits, done). The S_LEFT state sets up the leftover; each
// leftover unit then costs a scan through the quota memory (fewer units
// than shares); then the n results stream out one per cycle in load
// order, and busy falls in the cycle of the last result. An error holds
// busy for the check cycle only and gives a single result in the cycle
// after it. Results appear for one cycle on o_strobe and cannot be held
// off. total_length is written through the config channel, which is
// ready only while idle.
`default_nettype none
module largest_remainder_apportion (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire lra_pkg::t_entry               i_entry,
    output logic                               o_strobe,
    output lra_pkg::t_result                   o_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lra_pkg::LENGTH_BITS-1:0] i_cfg_data
);
    localparam int LW = lra_pkg::LENGTH_BITS;
    localparam int CW = lra_pkg::CNT_W;
    localparam int IW = lra_pkg::IDX_W;
    localparam int SW = lra_pkg::SUM_W;
    localparam int MX = lra_pkg::MAX_ENTRIES;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_RD, S_MUL, S_DIV, S_WR, S_LEFT, S_SCAN, S_OUT
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_cnt;
    logic [SW-1:0]            r_fixed;
    logic [SW-1:0]            r_weight;
    logic [LW-1:0]            r_total;
    logic [LW-1:0]            r_rest;
    logic [LW-1:0]            r_used;
    logic [CW-1:0]            r_idx;
    logic                     r_pv;
    logic [IW-1:0]            r_pidx;
    logic [CW-1:0]            r_left;
    logic [MX-1:0]            r_given;
    logic                     r_found;
    logic [IW-1:0]            r_best;
    logic [SW-1:0]            r_best_rem;
    logic [LW-1:0]            r_res;
    logic [SW-1:0]            r_rem;
    logic                     r_sh;
    logic [lra_pkg::PROD_W-1:0] r_prod;
    logic                     r_div_go;
    logic                     r_strobe;
    lra_pkg::t_result         r_result;

    logic                     accept;
    logic                     store;
    lra_pkg::t_ent_word       a_wdata;
    lra_pkg::t_ent_word       a_rdata;
    lra_pkg::t_quota_word     b_wdata;
    lra_pkg::t_quota_word     b_rdata;
    lra_pkg::t_div_req        div_req;
    lra_pkg::t_div_rsp        div_rsp;
    logic [LW:0]              rest_full;
    logic                     last_data;
    logic                     cand;
    logic                     fin_found;
    logic [IW-1:0]            fin_best;

    assign accept      = start && !busy;
    assign store       = accept && (r_cnt < CW'(MX));
    assign busy        = (r_state != S_LOAD);
    assign o_cfg_ready = (r_state == S_LOAD);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    assign a_wdata.share = i_entry.entry_is_share;
    assign a_wdata.value = i_entry.entry_value;
    assign b_wdata.share = r_sh;
    assign b_wdata.res   = r_res;
    assign b_wdata.rem   = r_rem;

    lra_ram #(.WIDTH($bits(lra_pkg::t_ent_word)), .DEPTH(MX)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (a_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (a_rdata)
    );

    lra_ram #(.WIDTH($bits(lra_pkg::t_quota_word)), .DEPTH(MX)) u_quota_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (b_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (b_rdata)
    );

    assign div_req.start    = r_div_go;
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_weight;

    lra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign rest_full = {1'b0, r_total} - r_fixed[LW:0];
    assign last_data = r_pv && (CW'(r_pidx) == r_cnt - 1'b1);
    assign cand      = b_rdata.share && !r_given[r_pidx]
                       && (!r_found || (b_rdata.rem > r_best_rem));
    assign fin_found = r_found || cand;
    assign fin_best  = cand ? r_pidx : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_fixed  <= '0;
            r_weight <= '0;
            r_total  <= '0;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_div_go <= 1'b0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
            r_given  <= '0;
            r_left   <= '0;
            r_used   <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        r_total <= i_cfg_data;
                    end
                    if (store) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (i_entry.entry_is_share) begin
                            r_weight <= r_weight + SW'(i_entry.entry_value);
                        end else begin
                            r_fixed <= r_fixed + SW'(i_entry.entry_value);
                        end
                    end
                    if (accept && i_entry.entry_last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_idx  <= '0;
                    r_used <= '0;
                    r_rest <= rest_full[LW-1:0];
                    if (r_fixed > SW'(r_total)) begin
                        r_strobe <= 1'b1;
                        r_result <= '{resolved_length: '0,
                                      status: lra_pkg::STAT_FIX_OVER, result_last: 1'b1};
                        r_cnt    <= '0;
                        r_fixed  <= '0;
                        r_weight <= '0;
                        r_state  <= S_LOAD;
                    end else if ((r_weight == '0) && (rest_full != '0)) begin
                        r_strobe <= 1'b1;
                        r_result <= '{resolved_length: '0,
                                      status: lra_pkg::STAT_NO_SHARE, result_last: 1'b1};
                        r_cnt    <= '0;
                        r_fixed  <= '0;
                        r_weight <= '0;
                        r_state  <= S_LOAD;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sh <= a_rdata.share;
                    if (!a_rdata.share) begin
                        r_res   <= a_rdata.value;
                        r_rem   <= '0;
                        r_state <= S_WR;
                    end else if (r_weight == '0) begin
                        r_res   <= '0;
                        r_rem   <= '0;
                        r_state <= S_WR;
                    end else begin
                        r_prod   <= a_rdata.value * r_rest;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        // Floor quota never exceeds the rest, so LW bits hold it.
                        r_res   <= div_rsp.quot[LW-1:0];
                        r_rem   <= div_rsp.rem;
                        r_used  <= r_used + div_rsp.quot[LW-1:0];
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_idx == r_cnt - 1'b1) begin
                        r_state <= S_LEFT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_LEFT: begin
                    r_idx   <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_given <= '0;
                    r_left  <= CW'(r_rest - r_used);
                    r_state <= (r_rest == r_used) ? S_OUT : S_SCAN;
                end
                S_SCAN: begin
                    if (r_idx < r_cnt) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && cand) begin
                        r_found    <= 1'b1;
                        r_best     <= r_pidx;
                        r_best_rem <= b_rdata.rem;
                    end
                    if (last_data) begin
                        // Award one unit to the winner, then rescan or finish.
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                        if (fin_found) begin
                            r_given[fin_best] <= 1'b1;
                            r_left <= r_left - 1'b1;
                        end
                        if (!fin_found || (r_left == CW'(1))) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (r_idx < r_cnt) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        r_strobe <= 1'b1;
                        r_result <= '{resolved_length: b_rdata.res + LW'(r_given[r_pidx]),
                                      status: lra_pkg::STAT_OK, result_last: last_data};
                    end
                    if (last_data) begin
                        r_pv     <= 1'b0;
                        r_cnt    <= '0;
                        r_fixed  <= '0;
                        r_weight <= '0;
                        r_state  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

`include "largest_remainder_apportion_assert.svh"

    `LRA_ASSERT(a_mid_result_busy, o_strobe && !o_result.result_last |-> busy, "result mid-run while idle")
    `LRA_ASSERT(a_final_idle, o_strobe && o_result.result_last |-> !busy, "not idle after final result")
    `LRA_ASSERT(a_error_single, o_strobe && (o_result.status != lra_pkg::STAT_OK) |-> o_result.result_last && (o_result.resolved_length == '0), "error result malformed")
    `LRA_ASSERT(a_last_starts, start && !busy && i_entry.entry_last |=> busy, "last entry did not start the pass")
endmodule
`default_nettype wire
